/* src/nau_pkg.sv */
package nau_pkg;

  // Default sizes
  localparam int NUM_FEATURE_ROWS = 1024;
  localparam int DATA_LANES       = 512;
  localparam int PSQT_LANES       = 8;
  localparam int NUM_ACCUMULATORS = 2;
  localparam int LANES_PER_CYCLE  = 16;

  // Fixed port widths
  localparam int CMD_W     = 3;
  localparam int COUNT_W   = 2;
  localparam int ROW_IDX_W = 10;
  localparam int LANE_W    = 10;
  localparam int VALUE_W   = 16;
  localparam int RESULT_W  = 32;

  localparam int MAX_TERMS  = 4;
  localparam int TERM_IDX_W = 2;
  localparam int NT_W       = 3;
  localparam int MAX_COUNT  = 2;

  // Command codes on the input port
  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_BIAS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESET       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ        = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD_WEIGHT,
    OP_LOAD_BIAS,
    OP_RESET,
    OP_UPDATE,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic                 neg;
  } term_t;

  // Decoded command word passed from front to back
  typedef struct packed {
    op_t                         op;
    logic                        sel;
    logic                        active;
    logic [NT_W-1:0]             num_terms;
    term_t [MAX_TERMS-1:0]       terms;
    logic [ROW_IDX_W-1:0]        row;
    logic [LANE_W-1:0]           lane;
    logic [LANE_W-1:0]           chunk;
    logic [LANE_W-1:0]           offset;
    logic [VALUE_W-1:0]          value;
  } job_t;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic                is_read;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOAD_RD,
    B_LOAD_WR,
    B_RESET_RUN,
    B_RESET_END,
    B_UPD_RUN,
    B_UPD_END,
    B_READ_RD,
    B_READ_GET,
    B_RESULT
  } back_state_t;

  function automatic int clog2_min1(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* src/nau_ram.sv */
module nau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [nau_pkg::clog2_min1(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [nau_pkg::clog2_min1(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/nau_fifo.sv */
module nau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = nau_pkg::clog2_min1(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fifo count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("word pushed into full fifo");

endmodule

/* src/nau_front.sv */
module nau_front #(
  parameter int NUM_FEATURE_ROWS = nau_pkg::NUM_FEATURE_ROWS,
  parameter int NUM_ACCUMULATORS = nau_pkg::NUM_ACCUMULATORS,
  parameter int ROW_LANES        = nau_pkg::DATA_LANES + nau_pkg::PSQT_LANES,
  parameter int LANES_PER_CYCLE  = nau_pkg::LANES_PER_CYCLE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [nau_pkg::CMD_W-1:0]            command,
  input  logic                                 acc_select,
  input  logic [nau_pkg::COUNT_W-1:0]          add_count,
  input  logic [nau_pkg::COUNT_W-1:0]          sub_count,
  input  logic [nau_pkg::ROW_IDX_W-1:0]        add_feature_a,
  input  logic [nau_pkg::ROW_IDX_W-1:0]        add_feature_b,
  input  logic [nau_pkg::ROW_IDX_W-1:0]        sub_feature_a,
  input  logic [nau_pkg::ROW_IDX_W-1:0]        sub_feature_b,
  input  logic [nau_pkg::ROW_IDX_W-1:0]        weight_row,
  input  logic [nau_pkg::LANE_W-1:0]           lane,
  input  logic [nau_pkg::VALUE_W-1:0]          load_value,
  output nau_pkg::job_t                        job,
  output logic                                 job_push,
  input  logic                                 job_full
);

  localparam int LW     = nau_pkg::LANE_W;
  // lane / LANES_PER_CYCLE as a multiply by the rounded-up reciprocal;
  // exact for every LW-bit lane with this shift
  localparam int DIV_SH = LW + $clog2(LANES_PER_CYCLE);
  localparam int RECIP  = ((1 << DIV_SH) + LANES_PER_CYCLE - 1) / LANES_PER_CYCLE;
  localparam int PROD_W = DIV_SH + LW;

  nau_pkg::front_state_t state, state_next;

  logic [nau_pkg::CMD_W-1:0]     cmd_r;
  logic                          sel_r;
  logic [nau_pkg::COUNT_W-1:0]   addc_r;
  logic [nau_pkg::COUNT_W-1:0]   subc_r;
  logic [nau_pkg::ROW_IDX_W-1:0] add_a_r;
  logic [nau_pkg::ROW_IDX_W-1:0] add_b_r;
  logic [nau_pkg::ROW_IDX_W-1:0] sub_a_r;
  logic [nau_pkg::ROW_IDX_W-1:0] sub_b_r;
  logic [nau_pkg::ROW_IDX_W-1:0] row_r;
  logic [LW-1:0]                 lane_r;
  logic [nau_pkg::VALUE_W-1:0]   value_r;

  logic [PROD_W-1:0] quot_prod;
  logic [PROD_W-1:0] back_prod;
  logic [LW-1:0]     chunk;
  logic [LW-1:0]     rem;

  logic accept;

  assign accept    = push && !full;
  assign full      = (state != nau_pkg::F_IDLE);
  assign quot_prod = PROD_W'(lane_r) * PROD_W'(RECIP);
  assign chunk     = quot_prod[DIV_SH +: LW];
  assign back_prod = PROD_W'(chunk) * PROD_W'(LANES_PER_CYCLE);
  assign rem       = lane_r - back_prod[LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nau_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= command;
      sel_r   <= acc_select;
      addc_r  <= add_count;
      subc_r  <= sub_count;
      add_a_r <= add_feature_a;
      add_b_r <= add_feature_b;
      sub_a_r <= sub_feature_a;
      sub_b_r <= sub_feature_b;
      row_r   <= weight_row;
      lane_r  <= lane;
      value_r <= load_value;
    end
  end

  always_comb begin
    state_next = state;
    job_push   = 1'b0;
    case (state)
      nau_pkg::F_IDLE: begin
        if (accept) state_next = nau_pkg::F_PUSH;
      end
      nau_pkg::F_PUSH: begin
        job_push = !job_full;
        if (!job_full) state_next = nau_pkg::F_IDLE;
      end
      default: state_next = nau_pkg::F_IDLE;
    endcase
  end

  // decode
  logic [nau_pkg::COUNT_W-1:0]   add_n;
  logic [nau_pkg::COUNT_W-1:0]   sub_n;
  nau_pkg::term_t [nau_pkg::MAX_TERMS-1:0] cand;
  logic [nau_pkg::MAX_TERMS-1:0] cand_v;
  nau_pkg::term_t [nau_pkg::MAX_TERMS-1:0] terms;
  logic [nau_pkg::NT_W-1:0]      nt;
  logic                          sel_ok;
  logic                          lane_ok;
  logic                          row_ok;

  always_comb begin
    add_n = (addc_r > nau_pkg::COUNT_W'(nau_pkg::MAX_COUNT))
            ? nau_pkg::COUNT_W'(nau_pkg::MAX_COUNT) : addc_r;
    sub_n = (subc_r > nau_pkg::COUNT_W'(nau_pkg::MAX_COUNT))
            ? nau_pkg::COUNT_W'(nau_pkg::MAX_COUNT) : subc_r;
    cand[0] = '{row: add_a_r, neg: 1'b0};
    cand[1] = '{row: add_b_r, neg: 1'b0};
    cand[2] = '{row: sub_a_r, neg: 1'b1};
    cand[3] = '{row: sub_b_r, neg: 1'b1};
    cand_v[0] = (add_n >= 2'd1) && (32'(add_a_r) < NUM_FEATURE_ROWS);
    cand_v[1] = (add_n >= 2'd2) && (32'(add_b_r) < NUM_FEATURE_ROWS);
    cand_v[2] = (sub_n >= 2'd1) && (32'(sub_a_r) < NUM_FEATURE_ROWS);
    cand_v[3] = (sub_n >= 2'd2) && (32'(sub_b_r) < NUM_FEATURE_ROWS);
    // pack live terms to the front; rows out of range add nothing
    terms = '0;
    nt    = '0;
    for (int i = 0; i < nau_pkg::MAX_TERMS; i++) begin
      if (cand_v[i]) begin
        terms[nt[nau_pkg::TERM_IDX_W-1:0]] = cand[i];
        nt = nt + 1'b1;
      end
    end
    sel_ok  = (32'(sel_r) < NUM_ACCUMULATORS);
    lane_ok = (32'(lane_r) < ROW_LANES);
    row_ok  = (32'(row_r) < NUM_FEATURE_ROWS);

    job.sel       = sel_r;
    job.num_terms = nt;
    job.terms     = terms;
    job.row       = row_r;
    job.lane      = lane_r;
    job.chunk     = chunk;
    job.offset    = rem;
    job.value     = value_r;
    case (cmd_r)
      nau_pkg::CMD_LOAD_WEIGHT: begin
        job.op     = nau_pkg::OP_LOAD_WEIGHT;
        job.active = row_ok && lane_ok;
      end
      nau_pkg::CMD_LOAD_BIAS: begin
        job.op     = nau_pkg::OP_LOAD_BIAS;
        job.active = lane_ok;
      end
      nau_pkg::CMD_RESET: begin
        job.op     = nau_pkg::OP_RESET;
        job.active = sel_ok;
      end
      nau_pkg::CMD_UPDATE: begin
        job.op     = nau_pkg::OP_UPDATE;
        job.active = sel_ok && (nt != '0);
      end
      nau_pkg::CMD_READ: begin
        job.op     = nau_pkg::OP_READ;
        job.active = sel_ok && lane_ok;
      end
      default: begin
        job.op     = nau_pkg::OP_NONE;
        job.active = 1'b0;
      end
    endcase
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == nau_pkg::F_PUSH |-> 32'(rem) < LANES_PER_CYCLE)
    else $error("lane remainder not below lanes per cycle");

endmodule

/* src/nau_back.sv */
module nau_back #(
  parameter int NUM_FEATURE_ROWS = nau_pkg::NUM_FEATURE_ROWS,
  parameter int DATA_LANES       = nau_pkg::DATA_LANES,
  parameter int PSQT_LANES       = nau_pkg::PSQT_LANES,
  parameter int NUM_ACCUMULATORS = nau_pkg::NUM_ACCUMULATORS,
  parameter int LANES_PER_CYCLE  = nau_pkg::LANES_PER_CYCLE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  nau_pkg::job_t     job,
  output logic              job_pop,
  input  logic              res_full,
  output nau_pkg::result_t  res,
  output logic              res_push
);

  localparam int VW        = nau_pkg::VALUE_W;
  localparam int RW        = nau_pkg::RESULT_W;
  localparam int LPC       = LANES_PER_CYCLE;
  localparam int ROW_LANES = DATA_LANES + PSQT_LANES;
  localparam int CHUNKS    = (ROW_LANES + LPC - 1) / LPC;
  localparam int CHUNK_W   = nau_pkg::clog2_min1(CHUNKS);
  localparam int OFF_W     = nau_pkg::clog2_min1(LPC);
  localparam int W_DEPTH   = NUM_FEATURE_ROWS * CHUNKS;
  localparam int W_ADDR_W  = nau_pkg::clog2_min1(W_DEPTH);
  localparam int A_DEPTH   = NUM_ACCUMULATORS * CHUNKS;
  localparam int A_ADDR_W  = nau_pkg::clog2_min1(A_DEPTH);
  localparam int W_WIDTH   = LPC * VW;
  localparam int A_WIDTH   = LPC * RW;

  nau_pkg::back_state_t state, state_next;
  nau_pkg::job_t        job_r;

  logic [CHUNK_W-1:0]             cnt, cnt_next;
  logic [nau_pkg::TERM_IDX_W-1:0] term_idx, term_idx_next;
  logic                           pend, pend_next;
  logic [nau_pkg::TERM_IDX_W-1:0] pend_term, pend_term_next;
  logic [CHUNK_W-1:0]             pend_chunk, pend_chunk_next;
  logic [RW-1:0]                  res_value, res_value_next;
  logic                           res_is_read, res_is_read_next;
  logic [A_WIDTH-1:0]             sum;

  logic [CHUNK_W-1:0]   chunk_sel;
  logic [OFF_W-1:0]     off;
  logic                 is_last_term;
  logic                 upd_last;

  logic                 w_we;
  logic [W_ADDR_W-1:0]  w_addr;
  logic [W_WIDTH-1:0]   w_wdata;
  logic [W_WIDTH-1:0]   w_rdata;
  logic [nau_pkg::ROW_IDX_W-1:0] w_row;
  logic [CHUNK_W-1:0]   w_chunk;

  logic                 b_we;
  logic [CHUNK_W-1:0]   b_addr;
  logic [W_WIDTH-1:0]   b_wdata;
  logic [W_WIDTH-1:0]   b_rdata;

  logic                 a_we;
  logic [A_ADDR_W-1:0]  a_waddr;
  logic [A_ADDR_W-1:0]  a_raddr;
  logic [A_WIDTH-1:0]   a_wdata;
  logic [A_WIDTH-1:0]   a_rdata;
  logic [CHUNK_W-1:0]   a_rchunk;

  logic [A_WIDTH-1:0]   upd;
  logic [A_WIDTH-1:0]   bias_ext;
  logic [RW-1:0]        read_word;

  assign chunk_sel    = CHUNK_W'(job_r.chunk);
  assign off          = job_r.offset[OFF_W-1:0];
  assign is_last_term = ({1'b0, term_idx} == job_r.num_terms - nau_pkg::NT_W'(1));
  assign upd_last     = pend && ({1'b0, pend_term} == job_r.num_terms - nau_pkg::NT_W'(1));

  // weight address: row * CHUNKS + chunk
  assign w_row   = (state == nau_pkg::B_UPD_RUN) ? job_r.terms[term_idx].row : job_r.row;
  assign w_chunk = (state == nau_pkg::B_UPD_RUN) ? cnt : chunk_sel;
  assign w_addr  = W_ADDR_W'(W_ADDR_W'(w_row) * W_ADDR_W'(CHUNKS)) + W_ADDR_W'(w_chunk);

  assign b_addr  = (state == nau_pkg::B_RESET_RUN) ? cnt : chunk_sel;

  assign a_rchunk = (state == nau_pkg::B_READ_RD) ? chunk_sel : cnt;
  assign a_raddr  = A_ADDR_W'(A_ADDR_W'(job_r.sel) * A_ADDR_W'(CHUNKS)) + A_ADDR_W'(a_rchunk);
  assign a_waddr  = A_ADDR_W'(A_ADDR_W'(job_r.sel) * A_ADDR_W'(CHUNKS)) + A_ADDR_W'(pend_chunk);

  nau_ram #(.WIDTH(W_WIDTH), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_addr),
    .wdata (w_wdata),
    .raddr (w_addr),
    .rdata (w_rdata)
  );

  nau_ram #(.WIDTH(W_WIDTH), .DEPTH(CHUNKS)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_addr),
    .wdata (b_wdata),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  nau_ram #(.WIDTH(A_WIDTH), .DEPTH(A_DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // lane arithmetic; data lanes keep 32 bits and wrap to 16 on read
  always_comb begin
    for (int k = 0; k < LPC; k++) begin
      logic [RW-1:0] base;
      logic [RW-1:0] wext;
      base = (pend_term == '0) ? a_rdata[k*RW +: RW] : sum[k*RW +: RW];
      wext = {{(RW - VW){w_rdata[k*VW + VW - 1]}}, w_rdata[k*VW +: VW]};
      upd[k*RW +: RW]      = job_r.terms[pend_term].neg ? base - wext : base + wext;
      bias_ext[k*RW +: RW] = {{(RW - VW){b_rdata[k*VW + VW - 1]}}, b_rdata[k*VW +: VW]};
    end
  end

  always_comb begin
    w_wdata = w_rdata;
    w_wdata[off*VW +: VW] = job_r.value;
    b_wdata = b_rdata;
    b_wdata[off*VW +: VW] = job_r.value;
    read_word = a_rdata[off*RW +: RW];
    a_we    = pend && ((job_r.op == nau_pkg::OP_RESET) || upd_last);
    a_wdata = (job_r.op == nau_pkg::OP_RESET) ? bias_ext : upd;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    term_idx_next    = term_idx;
    pend_next        = 1'b0;
    pend_term_next   = pend_term;
    pend_chunk_next  = pend_chunk;
    res_value_next   = res_value;
    res_is_read_next = res_is_read;
    job_pop          = 1'b0;
    res_push         = 1'b0;
    w_we             = 1'b0;
    b_we             = 1'b0;
    case (state)
      nau_pkg::B_IDLE: begin
        if (!job_empty) begin
          job_pop          = 1'b1;
          cnt_next         = '0;
          term_idx_next    = '0;
          res_value_next   = '0;
          res_is_read_next = (job.op == nau_pkg::OP_READ);
          if (!job.active) begin
            state_next = nau_pkg::B_RESULT;
          end else begin
            case (job.op)
              nau_pkg::OP_LOAD_WEIGHT,
              nau_pkg::OP_LOAD_BIAS: state_next = nau_pkg::B_LOAD_RD;
              nau_pkg::OP_RESET:     state_next = nau_pkg::B_RESET_RUN;
              nau_pkg::OP_UPDATE:    state_next = nau_pkg::B_UPD_RUN;
              nau_pkg::OP_READ:      state_next = nau_pkg::B_READ_RD;
              default:               state_next = nau_pkg::B_RESULT;
            endcase
          end
        end
      end
      nau_pkg::B_LOAD_RD: begin
        state_next = nau_pkg::B_LOAD_WR;
      end
      nau_pkg::B_LOAD_WR: begin
        // read-modify-write of one lane in the chunk word
        w_we       = (job_r.op == nau_pkg::OP_LOAD_WEIGHT);
        b_we       = (job_r.op == nau_pkg::OP_LOAD_BIAS);
        state_next = nau_pkg::B_RESULT;
      end
      nau_pkg::B_RESET_RUN: begin
        pend_next       = 1'b1;
        pend_chunk_next = cnt;
        if (cnt == CHUNK_W'(CHUNKS - 1)) begin
          state_next = nau_pkg::B_RESET_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      nau_pkg::B_RESET_END: begin
        state_next = nau_pkg::B_RESULT;
      end
      nau_pkg::B_UPD_RUN: begin
        pend_next       = 1'b1;
        pend_term_next  = term_idx;
        pend_chunk_next = cnt;
        if (is_last_term) begin
          term_idx_next = '0;
          if (cnt == CHUNK_W'(CHUNKS - 1)) begin
            state_next = nau_pkg::B_UPD_END;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else begin
          term_idx_next = term_idx + 1'b1;
        end
      end
      nau_pkg::B_UPD_END: begin
        state_next = nau_pkg::B_RESULT;
      end
      nau_pkg::B_READ_RD: begin
        state_next = nau_pkg::B_READ_GET;
      end
      nau_pkg::B_READ_GET: begin
        if (32'(job_r.lane) < DATA_LANES) begin
          res_value_next = {{(RW - VW){read_word[VW-1]}}, read_word[VW-1:0]};
        end else begin
          res_value_next = read_word;
        end
        state_next = nau_pkg::B_RESULT;
      end
      nau_pkg::B_RESULT: begin
        res_push = !res_full;
        if (!res_full) state_next = nau_pkg::B_IDLE;
      end
      default: state_next = nau_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nau_pkg::B_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    if (pend) begin
      sum <= upd;
    end
    cnt         <= cnt_next;
    term_idx    <= term_idx_next;
    pend_term   <= pend_term_next;
    pend_chunk  <= pend_chunk_next;
    res_value   <= res_value_next;
    res_is_read <= res_is_read_next;
  end

  assign res.value   = res_value;
  assign res.is_read = res_is_read;

  a_upd_end_last: assert property (@(posedge clk) disable iff (rst)
    state == nau_pkg::B_UPD_END |-> pend && upd_last)
    else $error("update sweep ended before the last term of the last chunk");

  a_reset_end_chunk: assert property (@(posedge clk) disable iff (rst)
    state == nau_pkg::B_RESET_END |-> pend && pend_chunk == CHUNK_W'(CHUNKS - 1))
    else $error("reset sweep ended on the wrong chunk");

  a_acc_write_src: assert property (@(posedge clk) disable iff (rst)
    a_we |-> $past(state == nau_pkg::B_RESET_RUN || state == nau_pkg::B_UPD_RUN))
    else $error("accumulator written without an issued read");

endmodule

/* src/nnue_accumulator_update.sv */
// NNUE accumulator update engine. Commands enter through a queue-style port
// (push/full) and every command returns exactly one word on the result queue
// (empty/pop), in order. A front stage decodes the command and splits the lane
// index into chunk and offset with a reciprocal multiply; it registers each
// command on accept and hands it off to the back end, with which it overlaps
// through a two-entry command queue. The back end runs one command at a time
// against three single-port-read memories: weights and biases stored as chunk
// words of LANES_PER_CYCLE 16-bit lanes, and accumulators as chunk words of
// 32-bit lanes. With C = ceil((DATA_LANES+PSQT_LANES)/LANES_PER_CYCLE) chunks
// (33 by default), a load weight or load bias does a read-modify-write of one
// chunk word, a reset sweeps the C chunks and an update reads N rows per chunk,
// N being the number of feature rows in range (0 to 4); one weight-memory read
// per row per chunk sets the update time. Commands that do nothing go straight
// to their result. Memories have no reset: a weight or bias is undefined until
// loaded and an accumulator until its first reset command.
module nnue_accumulator_update #(
  parameter int NUM_FEATURE_ROWS = nau_pkg::NUM_FEATURE_ROWS,
  parameter int DATA_LANES       = nau_pkg::DATA_LANES,
  parameter int PSQT_LANES       = nau_pkg::PSQT_LANES,
  parameter int NUM_ACCUMULATORS = nau_pkg::NUM_ACCUMULATORS,
  parameter int LANES_PER_CYCLE  = nau_pkg::LANES_PER_CYCLE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [nau_pkg::CMD_W-1:0]             command,
  input  logic                                  acc_select,
  input  logic [nau_pkg::COUNT_W-1:0]           add_count,
  input  logic [nau_pkg::COUNT_W-1:0]           sub_count,
  input  logic [nau_pkg::ROW_IDX_W-1:0]         add_feature_a,
  input  logic [nau_pkg::ROW_IDX_W-1:0]         add_feature_b,
  input  logic [nau_pkg::ROW_IDX_W-1:0]         sub_feature_a,
  input  logic [nau_pkg::ROW_IDX_W-1:0]         sub_feature_b,
  input  logic [nau_pkg::ROW_IDX_W-1:0]         weight_row,
  input  logic [nau_pkg::LANE_W-1:0]            lane,
  input  logic signed [nau_pkg::VALUE_W-1:0]    load_value,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [nau_pkg::RESULT_W-1:0]   lane_value,
  output logic                                  is_read
);

  localparam int JOB_W = $bits(nau_pkg::job_t);
  localparam int RES_W = $bits(nau_pkg::result_t);

  nau_pkg::job_t    front_job;
  nau_pkg::job_t    back_job;
  logic [JOB_W-1:0] back_job_bits;
  logic             job_push;
  logic             job_full;
  logic             job_pop;
  logic             job_empty;

  nau_pkg::result_t back_res;
  nau_pkg::result_t out_res;
  logic [RES_W-1:0] out_res_bits;
  logic             res_push;
  logic             res_full;

  nau_front #(
    .NUM_FEATURE_ROWS (NUM_FEATURE_ROWS),
    .NUM_ACCUMULATORS (NUM_ACCUMULATORS),
    .ROW_LANES        (DATA_LANES + PSQT_LANES),
    .LANES_PER_CYCLE  (LANES_PER_CYCLE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .acc_select    (acc_select),
    .add_count     (add_count),
    .sub_count     (sub_count),
    .add_feature_a (add_feature_a),
    .add_feature_b (add_feature_b),
    .sub_feature_a (sub_feature_a),
    .sub_feature_b (sub_feature_b),
    .weight_row    (weight_row),
    .lane          (lane),
    .load_value    (load_value),
    .job           (front_job),
    .job_push      (job_push),
    .job_full      (job_full)
  );

  nau_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (front_job),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (back_job_bits),
    .empty (job_empty)
  );

  assign back_job = nau_pkg::job_t'(back_job_bits);

  nau_back #(
    .NUM_FEATURE_ROWS (NUM_FEATURE_ROWS),
    .DATA_LANES       (DATA_LANES),
    .PSQT_LANES       (PSQT_LANES),
    .NUM_ACCUMULATORS (NUM_ACCUMULATORS),
    .LANES_PER_CYCLE  (LANES_PER_CYCLE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (back_job),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res       (back_res),
    .res_push  (res_push)
  );

  nau_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res_bits),
    .empty (empty)
  );

  assign out_res    = nau_pkg::result_t'(out_res_bits);
  assign lane_value = out_res.value;
  assign is_read    = out_res.is_read;

endmodule
